/* rtl/ptcd_pkg.sv */
// ----------------------------------------------------------------------------
// ptcd_pkg
// Types, codes and character tables shared by the text compaction decoder.
// ----------------------------------------------------------------------------
package ptcd_pkg;

	localparam int unsigned CW_W = 10;

	localparam logic [CW_W-1:0] CW_TEXT_LATCH  = 10'd900;
	localparam logic [CW_W-1:0] CW_BYTE_LATCH  = 10'd901;
	localparam logic [CW_W-1:0] CW_NUM_LATCH   = 10'd902;
	localparam logic [CW_W-1:0] CW_BYTE_SHIFT  = 10'd913;
	localparam logic [CW_W-1:0] CW_BYTE_LATCH6 = 10'd924;

	// reciprocal of 30 as 1093 / 2^15, exact floor for codewords below 900
	localparam logic [10:0] RECIP30 = 11'd1093;
	localparam logic [9:0]  DIV30   = 10'd30;

	localparam logic [4:0] V_SPACE = 5'd26;
	localparam logic [4:0] V_LC25  = 5'd25;
	localparam logic [4:0] V_LC27  = 5'd27;
	localparam logic [4:0] V_LC28  = 5'd28;
	localparam logic [4:0] V_LC29  = 5'd29;

	typedef enum logic [2:0] {
		SM_ALPHA  = 3'd0,
		SM_LOWER  = 3'd1,
		SM_MIXED  = 3'd2,
		SM_PUNCT  = 3'd3,
		SM_ASHIFT = 3'd4,
		SM_PSHIFT = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TEXT = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_EXIT = 2'd2
	} kind_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
		mode_t      mode;
		mode_t      saved;
	} half_t;

	// decoded results of one codeword
	typedef struct packed {
		logic       one;
		logic       two;
		logic [7:0] b0;
		kind_t      k0;
		logic [7:0] b1;
	} res_t;

	function automatic logic [7:0] punct_ch(input logic [4:0] v);
		logic [7:0] c;
		begin
			case (v)
				5'd0:  c = 8'h3B;
				5'd1:  c = 8'h3C;
				5'd2:  c = 8'h3E;
				5'd3:  c = 8'h40;
				5'd4:  c = 8'h5B;
				5'd5:  c = 8'h5C;
				5'd6:  c = 8'h5D;
				5'd7:  c = 8'h5F;
				5'd8:  c = 8'h60;
				5'd9:  c = 8'h7E;
				5'd10: c = 8'h21;
				5'd11: c = 8'h0D;
				5'd12: c = 8'h09;
				5'd13: c = 8'h2C;
				5'd14: c = 8'h3A;
				5'd15: c = 8'h0A;
				5'd16: c = 8'h2D;
				5'd17: c = 8'h2E;
				5'd18: c = 8'h24;
				5'd19: c = 8'h2F;
				5'd20: c = 8'h22;
				5'd21: c = 8'h7C;
				5'd22: c = 8'h2A;
				5'd23: c = 8'h28;
				5'd24: c = 8'h29;
				5'd25: c = 8'h3F;
				5'd26: c = 8'h7B;
				5'd27: c = 8'h7D;
				5'd28: c = 8'h27;
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

	function automatic logic [7:0] mixed_ch(input logic [4:0] v);
		logic [7:0] c;
		begin
			case (v)
				5'd10: c = 8'h26;
				5'd11: c = 8'h0D;
				5'd12: c = 8'h09;
				5'd13: c = 8'h2C;
				5'd14: c = 8'h3A;
				5'd15: c = 8'h23;
				5'd16: c = 8'h2D;
				5'd17: c = 8'h2E;
				5'd18: c = 8'h24;
				5'd19: c = 8'h2F;
				5'd20: c = 8'h2B;
				5'd21: c = 8'h25;
				5'd22: c = 8'h2A;
				5'd23: c = 8'h3D;
				5'd24: c = 8'h5E;
				default: c = 8'h30 + {3'b000, v};
			endcase
			return c;
		end
	endfunction

	function automatic half_t decode_half(input mode_t m, input mode_t sv,
			input logic [4:0] v);
		half_t h;
		begin
			h.emit  = 1'b0;
			h.ch    = 8'h00;
			h.mode  = m;
			h.saved = sv;
			case (m)
				SM_LOWER: begin
					if (v < V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h61 + {3'b000, v};
					end else if (v == V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h20;
					end else if (v == V_LC27) begin
						h.saved = SM_LOWER;
						h.mode  = SM_ASHIFT;
					end else if (v == V_LC28) begin
						h.mode = SM_MIXED;
					end else begin
						h.saved = SM_LOWER;
						h.mode  = SM_PSHIFT;
					end
				end
				SM_MIXED: begin
					if (v < V_LC25) begin
						h.emit = 1'b1;
						h.ch   = mixed_ch(v);
					end else if (v == V_LC25) begin
						h.mode = SM_PUNCT;
					end else if (v == V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h20;
					end else if (v == V_LC27) begin
						h.mode = SM_LOWER;
					end else if (v == V_LC28) begin
						h.mode = SM_ALPHA;
					end else begin
						h.saved = SM_MIXED;
						h.mode  = SM_PSHIFT;
					end
				end
				SM_PUNCT: begin
					if (v < V_LC29) begin
						h.emit = 1'b1;
						h.ch   = punct_ch(v);
					end else begin
						h.mode = SM_ALPHA;
					end
				end
				SM_ASHIFT: begin
					h.mode = sv;
					if (v < V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h41 + {3'b000, v};
					end else if (v == V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h20;
					end
				end
				SM_PSHIFT: begin
					h.mode = sv;
					if (v < V_LC29) begin
						h.emit = 1'b1;
						h.ch   = punct_ch(v);
					end else begin
						h.mode = SM_ALPHA;
					end
				end
				default: begin
					if (v < V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h41 + {3'b000, v};
					end else if (v == V_SPACE) begin
						h.emit = 1'b1;
						h.ch   = 8'h20;
					end else if (v == V_LC27) begin
						h.mode = SM_LOWER;
					end else if (v == V_LC28) begin
						h.mode = SM_MIXED;
					end else begin
						h.saved = SM_ALPHA;
						h.mode  = SM_PSHIFT;
					end
				end
			endcase
			return h;
		end
	endfunction

endpackage

/* rtl/pdf417_text_compaction_decoder.sv */
// A codeword is captured in the input register, decoded, and its items are
// held in the result register; a busy result register stalls the input.
// Throughput: one codeword per cycle while out_stall is low and it yields at
// most one item; after a two-item codeword the input waits for the item port.
// Reset: arst_n clears sub-mode and saved mode to alpha, drops a pending byte
// shift and empties the input and result registers.
// ----------------------------------------------------------------------------
// pdf417_text_compaction_decoder
// PDF417 text compaction: codewords in, ASCII characters, shifted bytes and
// exit markers out.
// ----------------------------------------------------------------------------
module pdf417_text_compaction_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ptcd_pkg::CW_W-1:0] codeword,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic [1:0]                out_kind,
	output logic                      last
);
	import ptcd_pkg::*;

	logic            valid_s1;
	logic [CW_W-1:0] cw_s1;
	res_t            res;
	logic            free, adv, load;

	assign adv      = valid_s1 && (free || !res.one);
	assign load     = adv && res.one;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cw_s1 <= codeword;
		end
	end

	ptcd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cw     (cw_s1),
		.adv    (adv),
		.res    (res)
	);

	ptcd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.last      (last)
	);

endmodule

/* rtl/ptcd_decode.sv */
// ----------------------------------------------------------------------------
// ptcd_decode
// Sub-mode state and the decode of one registered codeword into up to two
// characters, a shifted byte or an exit marker. State advances when the result is taken or the codeword yields none.
// ----------------------------------------------------------------------------
module ptcd_decode (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ptcd_pkg::CW_W-1:0]    cw,
	input  logic                         adv,
	output ptcd_pkg::res_t               res
);
	import ptcd_pkg::*;

	mode_t       mode_q, saved_q, mode_d, saved_d;
	logic        pend_q, pend_d;
	logic [20:0] prod;
	logic [4:0]  hi, lo;
	logic [9:0]  hi_x30, rem;
	half_t       h0, h1;

	assign prod   = 21'(cw) * 21'(RECIP30);
	assign hi     = prod[19:15];
	assign hi_x30 = 10'(hi) * DIV30;
	assign rem    = cw - hi_x30;
	assign lo     = rem[4:0];

	assign h0 = decode_half(mode_q, saved_q, hi);
	assign h1 = decode_half(h0.mode, h0.saved, lo);

	always_comb begin
		mode_d  = mode_q;
		saved_d = saved_q;
		pend_d  = pend_q;
		res     = '0;
		res.k0  = KIND_TEXT;
		if (pend_q) begin
			pend_d = 1'b0;
			if (mode_q == SM_ASHIFT || mode_q == SM_PSHIFT) begin
				mode_d = saved_q;
			end
			res.one = 1'b1;
			res.b0  = cw[7:0];
			res.k0  = KIND_BYTE;
		end else if (cw < CW_TEXT_LATCH) begin
			mode_d  = h1.mode;
			saved_d = h1.saved;
			res.one = h0.emit || h1.emit;
			res.two = h0.emit && h1.emit;
			res.b0  = h0.emit ? h0.ch : h1.ch;
			res.b1  = h1.ch;
		end else if (cw == CW_TEXT_LATCH) begin
			mode_d  = SM_ALPHA;
			saved_d = SM_ALPHA;
		end else if (cw == CW_BYTE_LATCH || cw == CW_NUM_LATCH
				|| cw == CW_BYTE_LATCH6) begin
			mode_d  = SM_ALPHA;
			saved_d = SM_ALPHA;
			pend_d  = 1'b0;
			res.one = 1'b1;
			res.k0  = KIND_EXIT;
		end else if (cw == CW_BYTE_SHIFT) begin
			pend_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SM_ALPHA;
			saved_q <= SM_ALPHA;
			pend_q  <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_d;
			saved_q <= saved_d;
			pend_q  <= pend_d;
		end
	end

endmodule

/* rtl/ptcd_outbuf.sv */
// ----------------------------------------------------------------------------
// ptcd_outbuf
// Result register for the items of one codeword, sent one item per cycle
// while out_stall is low, last flag on the final one.
// ----------------------------------------------------------------------------
module ptcd_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  ptcd_pkg::res_t      res,
	output logic                free,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic [1:0]          out_kind,
	output logic                last
);
	import ptcd_pkg::*;

	logic       valid_q, two_q, idx_q;
	logic [7:0] b0_q, b1_q;
	kind_t      k0_q;
	logic       take;

	assign out_valid = valid_q;
	assign last      = idx_q || !two_q;
	assign out_byte  = idx_q ? b1_q : b0_q;
	assign out_kind  = idx_q ? KIND_TEXT : k0_q;
	assign take      = valid_q && !out_stall;
	assign free      = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			two_q   <= res.two;
			idx_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			b0_q <= res.b0;
			k0_q <= res.k0;
			b1_q <= res.b1;
		end
	end

endmodule
